### design/fec_shard_group_tracker_defines.svh
// Assertion macros shared by the shard group tracker modules.
// Expects clk and rst_n in the scope of each use.
`ifndef FEC_SHARD_GROUP_TRACKER_DEFINES_SVH
`define FEC_SHARD_GROUP_TRACKER_DEFINES_SVH

// same-cycle implication
`define FSGT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSGT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fsgt_pkg.sv
// Shared types and constants for the shard group tracker.
// No dependencies.
package fsgt_pkg;

    localparam int SEQ_W      = 32;
    localparam int LEN_W      = 16;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int COUNT_W    = 5;
    localparam int MASK_W     = 16;
    localparam int SLOT_OUT_W = 2;
    localparam int IDX_OUT_W  = 4;
    localparam int DIV_CNT_W  = $clog2(SEQ_W);

    localparam logic [LEN_W-1:0] HDR_BYTES = 16'd8;

    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PARITY = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_NEW      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TYPE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SHARDS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_SHARDS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_LOCATE,
        S_SCAN,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic locate;
        logic scan_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic in_bad;
        logic div_last;
        logic found;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

### design/fsgt_div.sv
// Restoring divider: 32-bit dividend by a narrow divisor, one bit a cycle.
// Depends on fsgt_pkg and the assertion macro header.
`include "fec_shard_group_tracker_defines.svh"

module fsgt_div #(
    parameter int DIVISOR_W = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fsgt_pkg::SEQ_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]        divisor,
    output logic                        last,
    output logic [fsgt_pkg::SEQ_W-1:0]  quotient,
    output logic [DIVISOR_W-1:0]        remainder
);
    import fsgt_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(SEQ_W - 1);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SEQ_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] div_reg;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SEQ_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == LAST_CNT)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SEQ_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign last      = busy_reg && (cnt_reg == LAST_CNT);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `FSGT_ASSERT_NEXT(a_div_start_busy, start, busy_reg, "divider not busy after start")
    `FSGT_ASSERT_NEXT(a_div_stops, last && !start, !busy_reg, "divider ran past last step")

endmodule

### design/fsgt_datapath.sv
// Datapath: config registers, input latch, divider, group slots, output register.
// Depends on fsgt_pkg, fsgt_div and the assertion macro header.
`include "fec_shard_group_tracker_defines.svh"

module fsgt_datapath #(
    parameter int MAX_SHARDS  = 16,
    parameter int GROUP_SLOTS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fsgt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsgt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [fsgt_pkg::SEQ_W-1:0]      seq_id,
    input  logic [fsgt_pkg::KIND_W-1:0]     kind,
    input  logic [fsgt_pkg::LEN_W-1:0]      size_field,
    input  logic [fsgt_pkg::LEN_W-1:0]      packet_len,
    input  fsgt_pkg::dp_cmd_t               cmd,
    output fsgt_pkg::dp_status_t            st,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [fsgt_pkg::STATUS_W-1:0]   status,
    output logic                            forward_data,
    output logic [fsgt_pkg::LEN_W-1:0]      forward_len,
    output logic [fsgt_pkg::SLOT_OUT_W-1:0] slot_id,
    output logic [fsgt_pkg::IDX_OUT_W-1:0]  shard_index,
    output logic                            group_done,
    output logic [fsgt_pkg::MASK_W-1:0]     missing_mask,
    output logic [fsgt_pkg::LEN_W-1:0]      recover_len
);
    import fsgt_pkg::*;

    localparam int TOT_W  = $clog2(MAX_SHARDS + 1);
    localparam int IDX_W  = $clog2(MAX_SHARDS);
    localparam int SLOT_W = $clog2(GROUP_SLOTS);

    // configuration
    logic [CFG_DATA_W-1:0] ds_reg;
    logic [CFG_DATA_W-1:0] ps_reg;

    // latched item
    logic                bad_reg;
    logic [STATUS_W-1:0] bad_status_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [LEN_W-1:0]    size_reg;
    logic [LEN_W-1:0]    plen_reg;

    // slot store
    logic [SEQ_W-1:0]      slot_group_reg   [GROUP_SLOTS];
    logic [COUNT_W-1:0]    slot_count_reg   [GROUP_SLOTS];
    logic [LEN_W-1:0]      slot_max_reg     [GROUP_SLOTS];
    logic [MAX_SHARDS-1:0] slot_present_reg [GROUP_SLOTS];
    logic [SEQ_W-1:0]      newest_reg;
    logic                  newest_valid_reg;

    // slot search
    logic [SLOT_W-1:0] sel_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] scan_reg;
    logic [SEQ_W-1:0]  old_grp_reg;

    // output word
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_fwd_reg;
    logic [LEN_W-1:0]      out_flen_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic [IDX_OUT_W-1:0]  out_idx_reg;
    logic                  out_done_reg;
    logic [MASK_W-1:0]     out_mask_reg;
    logic [LEN_W-1:0]      out_rlen_reg;

    logic [CFG_DATA_W:0] shard_sum;
    logic [TOT_W-1:0]    total;
    logic [SEQ_W-1:0]    grp;
    logic [TOT_W-1:0]    rem;
    logic [IDX_W-1:0]    idx;
    logic                div_last;

    logic [GROUP_SLOTS-1:0] match;
    logic [GROUP_SLOTS-1:0] free;
    logic [SLOT_W-1:0]      match_idx;
    logic [SLOT_W-1:0]      free_idx;
    logic [SEQ_W-1:0]       newest_diff;
    logic [SEQ_W-1:0]       cand_group;
    logic [SEQ_W-1:0]       cand_diff;
    logic                   scan_last;

    logic [MAX_SHARDS-1:0] cur_present;
    logic [COUNT_W-1:0]    cur_count;
    logic [LEN_W-1:0]      cur_max;
    logic [MAX_SHARDS-1:0] onehot;
    logic                  dup;
    logic [MAX_SHARDS-1:0] present_new;
    logic [COUNT_W-1:0]    count_new;
    logic [LEN_W-1:0]      pay_len;
    logic [LEN_W-1:0]      max_new;
    logic                  done;
    logic [MASK_W:0]       data_mask_w;
    logic [MASK_W-1:0]     present_pad;
    logic [MASK_W-1:0]     miss;
    logic [LEN_W-1:0]      rec_len;
    logic                  fwd;

    logic [SEQ_W-1:0]      post_group   [GROUP_SLOTS];
    logic [COUNT_W-1:0]    post_count   [GROUP_SLOTS];
    logic [LEN_W-1:0]      post_max     [GROUP_SLOTS];
    logic [MAX_SHARDS-1:0] post_present [GROUP_SLOTS];
    logic [SEQ_W-1:0]      age_diff     [GROUP_SLOTS];
    logic [GROUP_SLOTS-1:0] age;

    logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;
    logic [IDX_W+IDX_OUT_W-1:0]   idx_wide;

    // total shard count, saturated and never zero
    always_comb
    begin
        shard_sum = {1'b0, ds_reg} + {1'b0, ps_reg};
        if (int'(shard_sum) > MAX_SHARDS)
        begin
            total = TOT_W'(MAX_SHARDS);
        end
        else if (shard_sum == '0)
        begin
            total = TOT_W'(1);
        end
        else
        begin
            total = TOT_W'(shard_sum);
        end
    end

    fsgt_div #(
        .DIVISOR_W (TOT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (seq_id),
        .divisor   (total),
        .last      (div_last),
        .quotient  (grp),
        .remainder (rem)
    );

    assign idx = rem[IDX_W-1:0];

    // find a live slot for this group, else the first empty one
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = GROUP_SLOTS - 1; i >= 0; i--)
        begin
            match[i] = (slot_count_reg[i] != '0) && (slot_group_reg[i] == grp);
            free[i]  = (slot_count_reg[i] == '0);
            if (match[i])
            begin
                match_idx = SLOT_W'(i);
            end
            if (free[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
        newest_diff = grp - newest_reg;
        cand_group  = slot_group_reg[scan_reg];
        cand_diff   = cand_group - old_grp_reg;
        scan_last   = (scan_reg == SLOT_W'(GROUP_SLOTS - 1));
    end

    // shard update on the chosen slot; an evicted or fresh slot counts as empty
    always_comb
    begin
        cur_present = hit_reg ? slot_present_reg[sel_reg] : '0;
        cur_count   = hit_reg ? slot_count_reg[sel_reg] : '0;
        cur_max     = hit_reg ? slot_max_reg[sel_reg] : '0;
        onehot      = '0;
        onehot[idx] = 1'b1;
        dup         = |(cur_present & onehot);
        present_new = cur_present | onehot;
        count_new   = cur_count + COUNT_W'(1);
        pay_len     = plen_reg - HDR_BYTES;
        max_new     = (pay_len > cur_max) ? pay_len : cur_max;
        done        = count_new >= COUNT_W'(ds_reg);
        data_mask_w = ((MASK_W + 1)'(1) << ds_reg) - (MASK_W + 1)'(1);
        miss        = ~present_pad & data_mask_w[MASK_W-1:0];
        rec_len     = (max_new != '0) ? max_new : LEN_W'(1);
        fwd         = (kind_reg == KIND_DATA);
    end

    // shards beyond the bitmap read as absent
    for (genvar b = 0; b < MASK_W; b++)
    begin : g_pad
        if (b < MAX_SHARDS)
        begin : g_in
            assign present_pad[b] = present_new[b];
        end
        else
        begin : g_out
            assign present_pad[b] = 1'b0;
        end
    end

    // slot contents after the update, then ageing against the newest group
    always_comb
    begin
        for (int i = 0; i < GROUP_SLOTS; i++)
        begin
            post_group[i]   = slot_group_reg[i];
            post_count[i]   = slot_count_reg[i];
            post_max[i]     = slot_max_reg[i];
            post_present[i] = slot_present_reg[i];
            if (SLOT_W'(i) == sel_reg)
            begin
                if (done)
                begin
                    post_group[i]   = '0;
                    post_count[i]   = '0;
                    post_max[i]     = '0;
                    post_present[i] = '0;
                end
                else
                begin
                    post_group[i]   = grp;
                    post_count[i]   = count_new;
                    post_max[i]     = max_new;
                    post_present[i] = present_new;
                end
            end
            age_diff[i] = newest_reg - post_group[i];
            age[i] = (post_count[i] != '0) && !age_diff[i][SEQ_W-1]
                     && (age_diff[i] > SEQ_W'(GROUP_SLOTS));
        end
        slot_wide = {{SLOT_OUT_W{1'b0}}, sel_reg};
        idx_wide  = {{IDX_OUT_W{1'b0}}, idx};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ds_reg <= CFG_DATA_W'(1);
            ps_reg <= CFG_DATA_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DATA_SHARDS:   ds_reg <= cfg_data;
                CFG_PARITY_SHARDS: ps_reg <= cfg_data;
                default:           ds_reg <= ds_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            bad_reg        <= st.in_bad;
            bad_status_reg <= (packet_len < HDR_BYTES) ? STATUS_SHORT : STATUS_BAD_TYPE;
            kind_reg       <= kind;
            size_reg       <= size_field;
            plen_reg       <= packet_len;
        end
    end

    // slot search: direct hit or empty slot, else walk for the oldest group
    always_ff @(posedge clk)
    begin
        if (cmd.locate)
        begin
            if (|match)
            begin
                sel_reg <= match_idx;
                hit_reg <= 1'b1;
            end
            else if (|free)
            begin
                sel_reg <= free_idx;
                hit_reg <= 1'b0;
            end
            else
            begin
                sel_reg     <= '0;
                hit_reg     <= 1'b0;
                old_grp_reg <= slot_group_reg[0];
                scan_reg    <= SLOT_W'(1);
            end
        end
        else if (cmd.scan_step)
        begin
            if (cand_diff[SEQ_W-1])
            begin
                sel_reg     <= scan_reg;
                old_grp_reg <= cand_group;
            end
            if (!scan_last)
            begin
                scan_reg <= scan_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg       <= '0;
            newest_valid_reg <= 1'b0;
            for (int i = 0; i < GROUP_SLOTS; i++)
            begin
                slot_group_reg[i]   <= '0;
                slot_count_reg[i]   <= '0;
                slot_max_reg[i]     <= '0;
                slot_present_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.locate)
            begin
                if (!newest_valid_reg || (!newest_diff[SEQ_W-1] && newest_diff != '0))
                begin
                    newest_reg <= grp;
                end
                newest_valid_reg <= 1'b1;
            end
            if (cmd.finish && !bad_reg && !dup)
            begin
                for (int i = 0; i < GROUP_SLOTS; i++)
                begin
                    if (age[i])
                    begin
                        slot_group_reg[i]   <= '0;
                        slot_count_reg[i]   <= '0;
                        slot_max_reg[i]     <= '0;
                        slot_present_reg[i] <= '0;
                    end
                    else
                    begin
                        slot_group_reg[i]   <= post_group[i];
                        slot_count_reg[i]   <= post_count[i];
                        slot_max_reg[i]     <= post_max[i];
                        slot_present_reg[i] <= post_present[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (bad_reg)
            begin
                out_status_reg <= bad_status_reg;
                out_fwd_reg    <= 1'b0;
                out_flen_reg   <= '0;
                out_slot_reg   <= '0;
                out_idx_reg    <= '0;
                out_done_reg   <= 1'b0;
                out_mask_reg   <= '0;
                out_rlen_reg   <= '0;
            end
            else
            begin
                out_status_reg <= dup ? STATUS_DUP : STATUS_NEW;
                out_fwd_reg    <= fwd;
                out_flen_reg   <= fwd ? size_reg : '0;
                out_slot_reg   <= slot_wide[SLOT_OUT_W-1:0];
                out_idx_reg    <= idx_wide[IDX_OUT_W-1:0];
                out_done_reg   <= !dup && done;
                out_mask_reg   <= (!dup && done) ? miss : '0;
                out_rlen_reg   <= (!dup && done) ? rec_len : '0;
            end
        end
    end

    always_comb
    begin
        st.in_bad    = (packet_len < HDR_BYTES) || ((kind != KIND_DATA) && (kind != KIND_PARITY));
        st.div_last  = div_last;
        st.found     = (|match) || (|free);
        st.scan_last = scan_last;
        st.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign forward_data = out_fwd_reg;
    assign forward_len  = out_flen_reg;
    assign slot_id      = out_slot_reg;
    assign shard_index  = out_idx_reg;
    assign group_done   = out_done_reg;
    assign missing_mask = out_mask_reg;
    assign recover_len  = out_rlen_reg;

    `FSGT_ASSERT_NEXT(a_finish_loads_word, cmd.finish, out_valid_reg, "finish left no word")
    `FSGT_ASSERT_NOW(a_done_is_new, out_valid_reg && out_done_reg, out_status_reg == STATUS_NEW, "group done on non-new shard")

endmodule

### design/fsgt_ctrl.sv
// Controller: sequences accept, divide, slot search and result write-back.
// Depends on fsgt_pkg and the assertion macro header.
`include "fec_shard_group_tracker_defines.svh"

module fsgt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fsgt_pkg::dp_status_t st,
    output fsgt_pkg::dp_cmd_t    cmd
);
    import fsgt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (st.in_bad)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (st.div_last)
                begin
                    state_next = S_LOCATE;
                end
            end
            S_LOCATE:
            begin
                cmd.locate = 1'b1;
                state_next = st.found ? S_FINISH : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the output register can take the word
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `FSGT_ASSERT_NOW(a_finish_needs_room, cmd.finish, st.out_free, "finish with output full")
    `FSGT_ASSERT_NEXT(a_good_item_divides, cmd.accept && !st.in_bad, state_reg == S_DIV, "good item skipped divide")

endmodule

### design/fec_shard_group_tracker.sv
// Shard group tracker. A well-formed header goes through the 32-step serial divide by
// the shard total, then the slot search, which walks for the oldest slot when no slot
// matches or is free, then the result write-back. One item is in flight at a time: the
// next is taken in the cycle after the result is written. Short or bad-type headers
// skip the divide and the slot search. Reset is asynchronous, active low, and empties
// every slot at once; both shard counts return to 1.
module fec_shard_group_tracker #(
    parameter int MAX_SHARDS  = 16,
    parameter int GROUP_SLOTS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fsgt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsgt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fsgt_pkg::SEQ_W-1:0]      seq_id,
    input  logic [fsgt_pkg::KIND_W-1:0]     kind,
    input  logic [fsgt_pkg::LEN_W-1:0]      size_field,
    input  logic [fsgt_pkg::LEN_W-1:0]      packet_len,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [fsgt_pkg::STATUS_W-1:0]   status,
    output logic                            forward_data,
    output logic [fsgt_pkg::LEN_W-1:0]      forward_len,
    output logic [fsgt_pkg::SLOT_OUT_W-1:0] slot_id,
    output logic [fsgt_pkg::IDX_OUT_W-1:0]  shard_index,
    output logic                            group_done,
    output logic [fsgt_pkg::MASK_W-1:0]     missing_mask,
    output logic [fsgt_pkg::LEN_W-1:0]      recover_len
);
    import fsgt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    fsgt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    fsgt_datapath #(
        .MAX_SHARDS  (MAX_SHARDS),
        .GROUP_SLOTS (GROUP_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .seq_id       (seq_id),
        .kind         (kind),
        .size_field   (size_field),
        .packet_len   (packet_len),
        .cmd          (cmd),
        .st           (st),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .status       (status),
        .forward_data (forward_data),
        .forward_len  (forward_len),
        .slot_id      (slot_id),
        .shard_index  (shard_index),
        .group_done   (group_done),
        .missing_mask (missing_mask),
        .recover_len  (recover_len)
    );

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for fec_shard_group_tracker: directed and random shard headers,
// with a scoreboard that predicts slot, completion and recovery words from its own model.
// Depends on fsgt_pkg and the tracker RTL only.
module testbench;
    import fsgt_pkg::*;

    localparam int SLOTS       = 3;
    localparam int SHARD_LIMIT = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int RAND_PHASES = 10;
    localparam int RAND_ITEMS  = 63;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic                  forward_data;
        logic [LEN_W-1:0]      forward_len;
        logic [SLOT_OUT_W-1:0] slot_id;
        logic [IDX_OUT_W-1:0]  shard_index;
        logic                  group_done;
        logic [MASK_W-1:0]     missing_mask;
        logic [LEN_W-1:0]      recover_len;
    } shard_result_t;

    class shard_group_scoreboard;
        bit [CFG_DATA_W-1:0] data_cnt;
        bit [CFG_DATA_W-1:0] parity_cnt;
        bit [SEQ_W-1:0]      slot_grp[SLOTS];
        bit [COUNT_W-1:0]    slot_cnt[SLOTS];
        bit [LEN_W-1:0]      slot_len[SLOTS];
        bit [MASK_W-1:0]     slot_seen[SLOTS];
        bit [SEQ_W-1:0]      newest_grp;
        bit                  newest_ok;
        shard_result_t       awaited_results[$];
        int                  mismatches;

        function new();
            data_cnt   = CFG_DATA_W'(1);
            parity_cnt = CFG_DATA_W'(1);
            for (int s = 0; s < SLOTS; s++)
                drop_slot(s);
            newest_grp = '0;
            newest_ok  = 1'b0;
            mismatches = 0;
        endfunction

        function void drop_slot(int s);
            slot_grp[s]  = '0;
            slot_cnt[s]  = '0;
            slot_len[s]  = '0;
            slot_seen[s] = '0;
        endfunction

        // signed distance a - b on the 32-bit ring
        function int wrap_gap(bit [SEQ_W-1:0] a, bit [SEQ_W-1:0] b);
            bit [SEQ_W-1:0] d;
            d = a - b;
            return $signed(d);
        endfunction

        function int unsigned total_shards();
            int unsigned t;
            t = data_cnt + parity_cnt;
            if (t > SHARD_LIMIT)
                t = SHARD_LIMIT;
            if (t == 0)
                t = 1;
            return t;
        endfunction

        function int find_slot(bit [SEQ_W-1:0] grp);
            int oldest;
            for (int s = 0; s < SLOTS; s++)
                if (slot_cnt[s] != 0 && slot_grp[s] == grp)
                    return s;
            for (int s = 0; s < SLOTS; s++)
                if (slot_cnt[s] == 0)
                begin
                    slot_grp[s] = grp;
                    return s;
                end
            oldest = 0;
            for (int s = 1; s < SLOTS; s++)
                if (wrap_gap(slot_grp[s], slot_grp[oldest]) < 0)
                    oldest = s;
            drop_slot(oldest);
            slot_grp[oldest] = grp;
            return oldest;
        endfunction

        function void note_header(bit [SEQ_W-1:0] seq, bit [KIND_W-1:0] knd,
                                  bit [LEN_W-1:0] size, bit [LEN_W-1:0] plen);
            shard_result_t   r;
            bit [SEQ_W-1:0]  total;
            bit [SEQ_W-1:0]  grp;
            bit [SEQ_W-1:0]  idx;
            bit [LEN_W-1:0]  payload;
            int              s;
            r = '0;
            if (plen < HDR_BYTES)
                r.status = STATUS_SHORT;
            else if (knd != KIND_DATA && knd != KIND_PARITY)
                r.status = STATUS_BAD_TYPE;
            else
            begin
                total = total_shards();
                grp   = seq / total;
                idx   = seq % total;
                if (!newest_ok)
                begin
                    newest_grp = grp;
                    newest_ok  = 1'b1;
                end
                else if (wrap_gap(grp, newest_grp) > 0)
                    newest_grp = grp;
                s = find_slot(grp);
                r.slot_id     = s[SLOT_OUT_W-1:0];
                r.shard_index = idx[IDX_OUT_W-1:0];
                // data payload goes out even for a repeated shard
                if (knd == KIND_DATA)
                begin
                    r.forward_data = 1'b1;
                    r.forward_len  = size;
                end
                if (slot_seen[s][idx[IDX_OUT_W-1:0]])
                    r.status = STATUS_DUP;
                else
                begin
                    r.status        = STATUS_NEW;
                    slot_seen[s][idx[IDX_OUT_W-1:0]] = 1'b1;
                    slot_cnt[s]     = slot_cnt[s] + 1'b1;
                    payload         = plen - HDR_BYTES;
                    if (payload > slot_len[s])
                        slot_len[s] = payload;
                    if (slot_cnt[s] >= data_cnt)
                    begin
                        for (int i = 0; i < data_cnt; i++)
                            if (!slot_seen[s][i])
                                r.missing_mask[i] = 1'b1;
                        r.recover_len = (slot_len[s] != 0) ? slot_len[s] : 16'd1;
                        r.group_done  = 1'b1;
                        drop_slot(s);
                    end
                    // stale groups only age out on a fresh shard
                    for (int a = 0; a < SLOTS; a++)
                        if (slot_cnt[a] != 0 && wrap_gap(newest_grp, slot_grp[a]) > SLOTS)
                            drop_slot(a);
                end
            end
            awaited_results.push_back(r);
        endfunction

        function string describe(shard_result_t r);
            return $sformatf("st=%0d fwd=%0d flen=%0d slot=%0d idx=%0d done=%0d miss=%h rlen=%0d",
                             r.status, r.forward_data, r.forward_len, r.slot_id,
                             r.shard_index, r.group_done, r.missing_mask, r.recover_len);
        endfunction

        function void check_result(shard_result_t got);
            shard_result_t want;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with none awaited: %s", $realtime, describe(got));
                return;
            end
            want = awaited_results.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("    expected %s", describe(want));
                    $display("    actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = CFG_DATA_SHARDS;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [SEQ_W-1:0]      seq_id     = '0;
    logic [KIND_W-1:0]     kind       = KIND_DATA;
    logic [LEN_W-1:0]      size_field = '0;
    logic [LEN_W-1:0]      packet_len = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic                  forward_data;
    logic [LEN_W-1:0]      forward_len;
    logic [SLOT_OUT_W-1:0] slot_id;
    logic [IDX_OUT_W-1:0]  shard_index;
    logic                  group_done;
    logic [MASK_W-1:0]     missing_mask;
    logic [LEN_W-1:0]      recover_len;

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_gap   = 0;

    shard_group_scoreboard sb = new();

    fec_shard_group_tracker #(
        .MAX_SHARDS  (SHARD_LIMIT),
        .GROUP_SLOTS (SLOTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .seq_id       (seq_id),
        .kind         (kind),
        .size_field   (size_field),
        .packet_len   (packet_len),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .forward_data (forward_data),
        .forward_len  (forward_len),
        .slot_id      (slot_id),
        .shard_index  (shard_index),
        .group_done   (group_done),
        .missing_mask (missing_mask),
        .recover_len  (recover_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: take a word, then hold stall for a freshly drawn number of cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_result(shard_result_t'({status, forward_data, forward_len, slot_id,
                                                 shard_index, group_done, missing_mask,
                                                 recover_len}));
                rx_gap = rx_quiet ? 0 : $urandom_range(0, 6);
            end
            else if (rx_gap > 0)
                rx_gap--;
            out_stall <= (rx_gap > 0);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_header(bit [SEQ_W-1:0] seq, bit [KIND_W-1:0] knd,
                               bit [LEN_W-1:0] size, bit [LEN_W-1:0] plen);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        seq_id     <= seq;
        kind       <= knd;
        size_field <= size;
        packet_len <= plen;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_header(seq, knd, size, plen);
    endtask

    // valid drops first, then this waits until no result is still awaited
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic retune(bit [CFG_DATA_W-1:0] d, bit [CFG_DATA_W-1:0] p);
        wait_for_results();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DATA_SHARDS;
        cfg_data  <= d;
        @(posedge clk);
        cfg_index <= CFG_PARITY_SHARDS;
        cfg_data  <= p;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.data_cnt   = d;
        sb.parity_cnt = p;
    endtask

    task automatic run_directed();
        // reset counts, two shards per group
        send_header(32'd0, KIND_DATA, 16'h0000, 16'd7);
        send_header(32'hFFFF_FFFF, 2'd3, 16'hFFFF, 16'hFFFF);
        send_header(32'd0, 2'd2, 16'h00A5, 16'd8);
        send_header(32'd1, KIND_PARITY, 16'h1234, 16'd8);
        // six shards per group: duplicates, completion with a hole, eviction, ageing
        retune(4'd4, 4'd2);
        send_header(32'd60, KIND_DATA, 16'h0101, 16'd100);
        send_header(32'd60, KIND_DATA, 16'h0202, 16'd100);
        send_header(32'd61, KIND_PARITY, 16'h0303, 16'd50);
        send_header(32'd61, KIND_PARITY, 16'h0404, 16'd50);
        send_header(32'd64, KIND_PARITY, 16'h0505, 16'd300);
        send_header(32'd62, KIND_DATA, 16'h0606, 16'd20);
        send_header(32'd66, KIND_DATA, 16'h0707, 16'd30);
        send_header(32'd72, KIND_DATA, 16'h0808, 16'd30);
        send_header(32'd78, KIND_DATA, 16'h0909, 16'd30);
        send_header(32'd84, KIND_PARITY, 16'h0A0A, 16'd30);
        send_header(32'd120, KIND_DATA, 16'h0B0B, 16'd30);
        // complete group with nothing missing
        retune(4'd2, 4'd1);
        send_header(32'd63, KIND_DATA, 16'h0C0C, 16'd40);
        send_header(32'd64, KIND_DATA, 16'h0D0D, 16'd41);
        // zero counts: total taken as one, every new shard completes at once
        retune(4'd0, 4'd0);
        send_header(32'd22, KIND_DATA, 16'h0E0E, 16'd9);
        send_header(32'd22, KIND_DATA, 16'h0F0F, 16'd8);
        // total saturates at sixteen
        retune(4'd15, 4'd15);
        send_header(32'hFFFF_FFFF, KIND_DATA, 16'hFFFF, 16'hFFFF);
        send_header(32'hFFFF_FFF0, KIND_PARITY, 16'h5555, 16'd8);
    endtask

    task automatic run_random(int items);
        int unsigned    total;
        int unsigned    pick;
        int unsigned    idx;
        bit [SEQ_W-1:0] base;
        bit [SEQ_W-1:0] grp;
        bit [SEQ_W-1:0] seq;
        bit [KIND_W-1:0] knd;
        bit [LEN_W-1:0] plen;
        total = sb.total_shards();
        if ($urandom_range(0, 3) == 0)
            base = (32'hFFFF_FFFF / total) - $urandom_range(0, 6);
        else
            base = $urandom / total;
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(0, 99);
            seq  = $urandom;
            knd  = KIND_W'($urandom_range(0, 1));
            plen = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(8, 65535))
                                               : LEN_W'($urandom_range(8, 1500));
            if (pick < 6)
                plen = LEN_W'($urandom_range(0, 7));
            else if (pick < 11)
                knd = KIND_W'($urandom_range(2, 3));
            else if (pick >= 17)
            begin
                // well-formed shard of a group close to the current one
                grp = base + $urandom_range(0, 4) - 1;
                idx = $urandom_range(0, total - 1);
                seq = grp * total + idx;
                knd = (idx < sb.data_cnt) ? KIND_DATA : KIND_PARITY;
                if ($urandom_range(0, 9) == 0)
                    knd = (knd == KIND_DATA) ? KIND_PARITY : KIND_DATA;
                if ($urandom_range(0, 7) == 0)
                    base = base + 1;
            end
            send_header(seq, knd, LEN_W'($urandom), plen);
            if (n == items / 2 || $urandom_range(0, 39) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin : stimulus
        bit [CFG_DATA_W-1:0] tune_data[RAND_PHASES];
        bit [CFG_DATA_W-1:0] tune_parity[RAND_PHASES];
        tune_data   = '{4'd15, 4'd3, 4'd1, 4'd7, 4'd0, 4'd4, 4'd1, 4'd15, 4'd2, 4'd0};
        tune_parity = '{4'd1, 4'd13, 4'd15, 4'd0, 4'd9, 4'd2, 4'd1, 4'd15, 4'd3, 4'd0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            retune(tune_data[ph], tune_parity[ph]);
            tx_quiet = (ph % 3 == 1);
            rx_quiet = (ph % 4 == 2);
            run_random(RAND_ITEMS);
        end
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
